// ===== hdl/max_pool_1d_argmax_defines.svh =====
// Assertion macros for the max pooling block.
`ifndef MAX_POOL_1D_ARGMAX_DEFINES_SVH
`define MAX_POOL_1D_ARGMAX_DEFINES_SVH

// cond must hold on every clock edge out of reset
`define MP1D_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold on the same edge as ante
`define MP1D_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mp1d_pkg.sv =====
package mp1d_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int NUM_CHANNELS_W = 5;
    localparam int IN_LENGTH_W    = 11;
    localparam int POOL_SIZE_W    = 4;

    localparam int VALUE_W    = 16;
    localparam int POSITION_W = 14;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd2;

    localparam logic [NUM_CHANNELS_W-1:0] RST_NUM_CHANNELS = 5'd1;
    localparam logic [IN_LENGTH_W-1:0]    RST_IN_LENGTH    = 11'd8;
    localparam logic [POOL_SIZE_W-1:0]    RST_POOL_SIZE    = 4'd2;

    localparam logic REQ_FORWARD  = 1'b0;
    localparam logic REQ_BACKWARD = 1'b1;

endpackage

// ===== hdl/max_pool_1d_argmax.sv =====
// 1D max pooling with argmax over channel-major Q8.8 samples, non-overlapping
// windows of pool_size. Forward samples (req_type 0) are taken one per cycle
// unless stalled; each completed window gives one word (maximum and its
// absolute position), via job and output registers, and its winning offset
// goes into an argmax memory of MAX_CHANNELS*MAX_LENGTH entries. A backward
// gradient (req_type 1) reads that memory (one registered read) and then
// streams pool_size words, or up to 2*pool_size-1 on the last window of a
// channel where the dropped tail is zero-filled; the single output register
// sends one word per cycle unless stalled, so a gradient holds the request
// side until its last word enters it. The argmax memory is not cleared: a
// gradient for a window never pooled returns an arbitrary position for its
// nonzero element. Configuration writes restart the pass counters.
`include "max_pool_1d_argmax_defines.svh"

module max_pool_1d_argmax #(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_LENGTH   = 1024,
    parameter int MAX_POOL     = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [mp1d_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mp1d_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic                                   req_type,
    input  logic signed [mp1d_pkg::VALUE_W-1:0]    sample_value,

    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic signed [mp1d_pkg::VALUE_W-1:0]    out_value,
    output logic [mp1d_pkg::POSITION_W-1:0]        out_position,
    output logic                                   last_of_run,
    output logic                                   end_of_pass
);
    import mp1d_pkg::*;

    localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
    localparam int POOL_W = $clog2(MAX_POOL + 1);
    localparam int OFF_W  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
    localparam int K_W    = $clog2(2 * MAX_POOL);
    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_LENGTH;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW0    = (LEN_W > POOL_W) ? LEN_W : POOL_W;
    localparam int CW1    = (CW0 > K_W) ? CW0 : K_W;
    localparam int CW     = ((CW1 > CH_W) ? CW1 : CH_W) + 2;

    function automatic logic [CH_W-1:0] eff_channels(input logic [NUM_CHANNELS_W-1:0] v);
        logic [CH_W-1:0] r;
        if (v == '0)
            r = CH_W'(1);
        else if (32'(v) > MAX_CHANNELS)
            r = CH_W'(MAX_CHANNELS);
        else
            r = CH_W'(v);
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] eff_length(input logic [IN_LENGTH_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
            r = LEN_W'(1);
        else if (32'(v) > MAX_LENGTH)
            r = LEN_W'(MAX_LENGTH);
        else
            r = LEN_W'(v);
        return r;
    endfunction

    function automatic logic [POOL_W-1:0] eff_pool(input logic [POOL_SIZE_W-1:0] v);
        logic [POOL_W-1:0] r;
        if (32'(v) > MAX_POOL)
            r = POOL_W'(MAX_POOL);
        else
            r = POOL_W'(v);
        return r;
    endfunction

    // configuration, stored already saturated
    logic [CH_W-1:0]   nch_reg, nch_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [POOL_W-1:0] pool_reg, pool_next;

    // pass counters
    logic              pass_reg, pass_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic signed [VALUE_W-1:0] run_max_reg, run_max_next;
    logic [OFF_W-1:0]  run_am_reg, run_am_next;

    // pending job feeding the output register
    logic              job_valid_reg, job_valid_next;
    logic              job_bwd_reg, job_bwd_next;
    logic signed [VALUE_W-1:0] job_value_reg, job_value_next;
    logic [ADDR_W-1:0] job_pos_reg, job_pos_next;
    logic [K_W-1:0]    job_total_reg, job_total_next;
    logic              job_end_reg, job_end_next;
    logic [K_W-1:0]    k_reg, k_next;

    logic [OFF_W-1:0]  argmax_mem [STORE_DEPTH];
    logic [OFF_W-1:0]  am_rd_reg;

    logic              res_valid_reg, res_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [POSITION_W-1:0] out_position_reg, out_position_next;
    logic              last_reg, last_next;
    logic              end_reg, end_next;

    // per-item decode
    logic              cfg_hit;
    logic              res_free, job_last, job_step, req_fire;
    logic              restart;
    logic [CH_W-1:0]   ch_c, ch_adv;
    logic [LEN_W-1:0]  pos_c, wstart_c, pos_inc;
    logic [OFF_W-1:0]  off_c, am_new;
    logic [ADDR_W-1:0] base_c, base_adv, store_addr;
    logic              fits_c, more_c, last_ch_c, take_c, complete_c, wrap_c;
    logic signed [VALUE_W-1:0] max_new;
    logic              store_we, store_re, grad_hit;

    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            CFG_NUM_CHANNELS, CFG_IN_LENGTH, CFG_POOL_SIZE: cfg_hit = cfg_we;
            default: cfg_hit = 1'b0;
        endcase
    end

    assign res_free = !res_valid_reg || res_ready;
    assign job_last = (k_reg == K_W'(job_total_reg - K_W'(1)));
    assign job_step = job_valid_reg && res_free;
    assign req_ready = !job_valid_reg || (res_free && job_last);
    assign req_fire = req_valid && req_ready;

    assign restart = (req_type != pass_reg);
    assign ch_c    = restart ? '0 : ch_reg;
    assign pos_c   = restart ? '0 : pos_reg;
    assign off_c   = restart ? '0 : off_reg;
    assign base_c  = restart ? '0 : base_reg;

    // in a forward pass the window start lags the sample index by the offset
    assign wstart_c = (req_type == REQ_BACKWARD) ? pos_c : LEN_W'(pos_c - LEN_W'(off_c));
    assign fits_c   = (pool_reg != '0)
                   && (CW'(wstart_c) + CW'(pool_reg) <= CW'(len_reg));
    assign more_c   = (CW'(wstart_c) + CW'(pool_reg) + CW'(pool_reg) <= CW'(len_reg));
    assign last_ch_c = (CW'(ch_c) + CW'(1) == CW'(nch_reg));
    assign take_c    = (off_c == '0) || (sample_value > run_max_reg);
    assign max_new   = take_c ? sample_value : run_max_reg;
    assign am_new    = take_c ? off_c : run_am_reg;
    assign complete_c = (CW'(off_c) + CW'(1) >= CW'(pool_reg));
    assign pos_inc   = LEN_W'(pos_c + LEN_W'(1));
    assign wrap_c    = (CW'(pos_c) + CW'(1) >= CW'(len_reg));
    assign ch_adv    = last_ch_c ? '0 : CH_W'(ch_c + CH_W'(1));
    assign base_adv  = last_ch_c ? '0 : ADDR_W'(base_c + ADDR_W'(len_reg));
    assign store_addr = ADDR_W'(base_c + ADDR_W'(wstart_c));

    assign store_we = req_fire && !cfg_hit && (req_type == REQ_FORWARD) && fits_c
                   && complete_c;
    assign store_re = req_fire && !cfg_hit && (req_type == REQ_BACKWARD);

    // only the window part of a backward run carries the gradient
    assign grad_hit = (CW'(k_reg) < CW'(pool_reg)) && (CW'(k_reg) == CW'(am_rd_reg));

    always_comb
    begin
        nch_next     = nch_reg;
        len_next     = len_reg;
        pool_next    = pool_reg;
        pass_next    = pass_reg;
        ch_next      = ch_reg;
        pos_next     = pos_reg;
        off_next     = off_reg;
        base_next    = base_reg;
        run_max_next = run_max_reg;
        run_am_next  = run_am_reg;

        job_valid_next = job_valid_reg;
        job_bwd_next   = job_bwd_reg;
        job_value_next = job_value_reg;
        job_pos_next   = job_pos_reg;
        job_total_next = job_total_reg;
        job_end_next   = job_end_reg;
        k_next         = k_reg;

        res_valid_next    = res_valid_reg;
        out_value_next    = out_value_reg;
        out_position_next = out_position_reg;
        last_next         = last_reg;
        end_next          = end_reg;

        if (res_ready)
            res_valid_next = 1'b0;

        if (job_step)
        begin
            res_valid_next    = 1'b1;
            out_value_next    = (!job_bwd_reg || grad_hit) ? job_value_reg : '0;
            out_position_next = POSITION_W'(job_pos_reg + ADDR_W'(k_reg));
            last_next         = job_last;
            end_next          = job_last && job_end_reg;
            if (job_last)
            begin
                job_valid_next = 1'b0;
                k_next         = '0;
            end
            else
            begin
                k_next = K_W'(k_reg + K_W'(1));
            end
        end

        if (cfg_hit)
        begin
            unique case (cfg_index)
                CFG_NUM_CHANNELS: nch_next  = eff_channels(cfg_data[NUM_CHANNELS_W-1:0]);
                CFG_IN_LENGTH:    len_next  = eff_length(cfg_data[IN_LENGTH_W-1:0]);
                CFG_POOL_SIZE:    pool_next = eff_pool(cfg_data[POOL_SIZE_W-1:0]);
                default: ;
            endcase
            ch_next   = '0;
            pos_next  = '0;
            off_next  = '0;
            base_next = '0;
        end
        else if (req_fire)
        begin
            pass_next = req_type;
            ch_next   = ch_c;
            pos_next  = pos_c;
            off_next  = off_c;
            base_next = base_c;
            if (req_type == REQ_FORWARD)
            begin
                if (fits_c)
                begin
                    run_max_next = max_new;
                    run_am_next  = am_new;
                    if (complete_c)
                    begin
                        off_next       = '0;
                        job_valid_next = 1'b1;
                        job_bwd_next   = 1'b0;
                        job_value_next = max_new;
                        job_pos_next   = ADDR_W'(store_addr + ADDR_W'(am_new));
                        job_total_next = K_W'(1);
                        job_end_next   = last_ch_c && !more_c;
                        k_next         = '0;
                    end
                    else
                    begin
                        off_next = OFF_W'(off_c + OFF_W'(1));
                    end
                end
                if (wrap_c)
                begin
                    pos_next  = '0;
                    off_next  = '0;
                    ch_next   = ch_adv;
                    base_next = base_adv;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            else if (fits_c)
            begin
                job_valid_next = 1'b1;
                job_bwd_next   = 1'b1;
                job_value_next = sample_value;
                job_pos_next   = store_addr;
                // last window of a channel also zero-fills the dropped tail
                job_total_next = more_c ? K_W'(pool_reg) : K_W'(len_reg - wstart_c);
                job_end_next   = last_ch_c && !more_c;
                k_next         = '0;
                if (more_c)
                begin
                    pos_next = LEN_W'(wstart_c + LEN_W'(pool_reg));
                end
                else
                begin
                    pos_next  = '0;
                    ch_next   = ch_adv;
                    base_next = base_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nch_reg       <= eff_channels(RST_NUM_CHANNELS);
            len_reg       <= eff_length(RST_IN_LENGTH);
            pool_reg      <= eff_pool(RST_POOL_SIZE);
            pass_reg      <= REQ_FORWARD;
            ch_reg        <= '0;
            pos_reg       <= '0;
            off_reg       <= '0;
            base_reg      <= '0;
            run_max_reg   <= '0;
            run_am_reg    <= '0;
            job_valid_reg <= 1'b0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            nch_reg       <= nch_next;
            len_reg       <= len_next;
            pool_reg      <= pool_next;
            pass_reg      <= pass_next;
            ch_reg        <= ch_next;
            pos_reg       <= pos_next;
            off_reg       <= off_next;
            base_reg      <= base_next;
            run_max_reg   <= run_max_next;
            run_am_reg    <= run_am_next;
            job_valid_reg <= job_valid_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_bwd_reg      <= job_bwd_next;
        job_value_reg    <= job_value_next;
        job_pos_reg      <= job_pos_next;
        job_total_reg    <= job_total_next;
        job_end_reg      <= job_end_next;
        out_value_reg    <= out_value_next;
        out_position_reg <= out_position_next;
        last_reg         <= last_next;
        end_reg          <= end_next;
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            argmax_mem[store_addr] <= am_new;
        if (store_re)
            am_rd_reg <= argmax_mem[store_addr];
    end

    assign res_valid    = res_valid_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_position_reg;
    assign last_of_run  = last_reg;
    assign end_of_pass  = end_reg;

    `MP1D_ASSERT_IMPLY(a_step_in_run, job_valid_reg, k_reg < job_total_reg, "word index past run")
    `MP1D_ASSERT_ALWAYS(a_pos_in_len, pos_reg < len_reg, "position counter past length")
    `MP1D_ASSERT_ALWAYS(a_ch_in_range, ch_reg < nch_reg, "channel counter past channel count")
    `MP1D_ASSERT_IMPLY(a_off_in_pool, pool_reg != '0, CW'(off_reg) < CW'(pool_reg),
        "window offset past pool size")

endmodule
